>>> hdl/mavg_pkg.sv
// Shared constants and types for the three-channel moving average filter.
package mavg_pkg;

  localparam int NUM_CH          = 3;
  localparam int MAX_ORDER_DEF   = 128;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CHANNEL_W = 2;
  localparam int SAMPLE_W  = 16;
  localparam int AVERAGE_W = 16;
  localparam int ORDER_W   = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd100;

  // register index, taken from paddr[3:2]; index equals the channel number
  typedef enum logic [1:0] {
    REG_ORDER_VOLTAGE = 2'd0,
    REG_ORDER_CURRENT = 2'd1,
    REG_ORDER_POWER   = 2'd2
  } reg_idx_t;

  localparam logic [CHANNEL_W-1:0] CH_LIMIT = CHANNEL_W'(NUM_CH);

endpackage

>>> hdl/mavg_if.sv
// Valid/ready channel interfaces for samples in and averages out.
interface mavg_in_if;
  logic                           valid;
  logic                           ready;
  logic [mavg_pkg::CHANNEL_W-1:0] channel;
  logic [mavg_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mavg_out_if;
  logic                           valid;
  logic                           ready;
  logic [mavg_pkg::AVERAGE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

>>> hdl/moving_average_filter_3ch.sv
// Three-channel moving average filter with ring store and bit-serial divider.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------
//  in_if    | in  | valid/ready           | channel[1:0], sample[15:0]
//  out_if   | out | valid/ready           | average[15:0]
//  APB      | in  | psel/penable, pready=1| paddr[3:0], pwdata/prdata[31:0]
//
// An item passes through these steps in order: accept and window read,
// sum update and store write, then one quotient bit per cycle
// from the restoring divider, then the load of the output register.
// An item on channel three skips the sum update and the divider.
// Reset is synchronous; the window store needs no clearing pass, since a
// per-channel fill count masks entries not written since the last clear.
// A new item is taken while a result waits in the output register; the
// divider result holds until that register is free.
module moving_average_filter_3ch #(
  parameter int MAX_ORDER   = mavg_pkg::MAX_ORDER_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mavg_in_if.sink                         in_if,
  mavg_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mavg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mavg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mavg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int NCH    = mavg_pkg::NUM_CH;
  localparam int POS_W  = $clog2(MAX_ORDER);
  localparam int FILL_W = $clog2(MAX_ORDER + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_ORDER);
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int DEPTH  = NCH * MAX_ORDER;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(MAX_ORDER);
  localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * MAX_ORDER);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_OUT  = 5'b01000,
    S_SKIP = 5'b10000
  } state_t;

  state_t                               state_r;
  logic [mavg_pkg::ORDER_W-1:0]         order_r [NCH];
  logic [SUM_W-1:0]                     sum_r   [NCH];
  logic [POS_W-1:0]                     pos_r   [NCH];
  logic [FILL_W-1:0]                    fill_r  [NCH];
  logic [SAMPLE_BITS-1:0]               win_mem_r [DEPTH];

  logic [mavg_pkg::CHANNEL_W-1:0]       ch_r;
  logic [SAMPLE_BITS-1:0]               smp_r;
  logic [ADDR_W-1:0]                    addr_r;
  logic [SAMPLE_BITS-1:0]               rd_data_r;
  logic                                 old_ok_r;
  logic [SUM_W-1:0]                     div_r;
  logic [FILL_W-1:0]                    rem_r;
  logic [FILL_W-1:0]                    divisor_r;
  logic [CNT_W-1:0]                     cnt_r;
  logic                                 out_valid_r;
  logic [mavg_pkg::AVERAGE_W-1:0]       out_avg_r;

  logic                                 in_acc;
  logic                                 out_free;
  logic                                 cfg_wr;
  logic [1:0]                           cfg_idx;
  logic [ADDR_W-1:0]                    rd_addr;
  logic [POS_W-1:0]                     in_pos;
  logic [ADDR_W-1:0]                    in_base;
  logic [FILL_W-1:0]                    eff_n;
  logic [SAMPLE_BITS-1:0]               old_smp;
  logic [SUM_W-1:0]                     sum_nxt;
  logic [FILL_W-1:0]                    pos_inc;
  logic [FILL_W-1:0]                    fill_nxt;
  logic [FILL_W:0]                      rem_sh;
  logic                                 q_bit;

  function automatic logic [FILL_W-1:0] eff_order(input logic [mavg_pkg::ORDER_W-1:0] o);
    logic [FILL_W-1:0] n;
    if (o == '0) begin
      n = FILL_W'(1);
    end else if (int'(o) > MAX_ORDER) begin
      n = FILL_W'(MAX_ORDER);
    end else begin
      n = FILL_W'(o);
    end
    return n;
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[3:2];

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  assign out_if.valid   = out_valid_r;
  assign out_if.average = out_avg_r;

  always_comb begin
    prdata = '0;
    case (mavg_pkg::reg_idx_t'(cfg_idx))
      mavg_pkg::REG_ORDER_VOLTAGE: prdata = mavg_pkg::CFG_DATA_W'(order_r[0]);
      mavg_pkg::REG_ORDER_CURRENT: prdata = mavg_pkg::CFG_DATA_W'(order_r[1]);
      mavg_pkg::REG_ORDER_POWER:   prdata = mavg_pkg::CFG_DATA_W'(order_r[2]);
      default:                     prdata = '0;
    endcase
  end

  // window address of the incoming item
  always_comb begin
    in_pos  = '0;
    in_base = '0;
    case (in_if.channel)
      2'd0: begin
        in_pos  = pos_r[0];
        in_base = '0;
      end
      2'd1: begin
        in_pos  = pos_r[1];
        in_base = BASE1;
      end
      2'd2: begin
        in_pos  = pos_r[2];
        in_base = BASE2;
      end
      default: begin
        in_pos  = '0;
        in_base = '0;
      end
    endcase
    rd_addr = in_base + ADDR_W'(in_pos);
  end

  // sum update for the item in hand (channel is below three in S_UPD)
  always_comb begin
    eff_n    = eff_order(order_r[ch_r[1:0]]);
    old_smp  = old_ok_r ? rd_data_r : '0;
    sum_nxt  = sum_r[ch_r] - SUM_W'(old_smp) + SUM_W'(smp_r);
    pos_inc  = FILL_W'(pos_r[ch_r]) + FILL_W'(1);
    fill_nxt = (fill_r[ch_r] == eff_n) ? fill_r[ch_r] : fill_r[ch_r] + FILL_W'(1);
  end

  assign rem_sh = {rem_r, div_r[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, divisor_r});

  // window store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      win_mem_r[addr_r] <= smp_r;
    end
    if (in_acc) begin
      rd_data_r <= win_mem_r[rd_addr];
    end
  end

  // item payload and divider datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r     <= in_if.channel;
      smp_r    <= SAMPLE_BITS'(in_if.sample);
      addr_r   <= rd_addr;
      old_ok_r <= (FILL_W'(in_pos) < fill_r[in_if.channel]);
    end
    case (state_r)
      S_UPD: begin
        div_r     <= sum_nxt;
        rem_r     <= '0;
        divisor_r <= eff_n;
        cnt_r     <= CNT_W'(SUM_W - 1);
      end
      S_DIV: begin
        div_r <= {div_r[SUM_W-2:0], q_bit};
        rem_r <= q_bit ? FILL_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[FILL_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (state_r == S_OUT && out_free) begin
      out_avg_r <= mavg_pkg::AVERAGE_W'(div_r);
    end else if (state_r == S_SKIP && out_free) begin
      out_avg_r <= '0;
    end
  end

  // control and per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        order_r[i] <= mavg_pkg::ORDER_RESET;
        sum_r[i]   <= '0;
        pos_r[i]   <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= (in_if.channel >= mavg_pkg::CH_LIMIT) ? S_SKIP : S_UPD;
          end
        end
        S_UPD: begin
          sum_r[ch_r]  <= sum_nxt;
          pos_r[ch_r]  <= (pos_inc >= eff_n) ? '0 : POS_W'(pos_inc);
          fill_r[ch_r] <= fill_nxt;
          state_r      <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT, S_SKIP: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // an order write clears that channel's window
      if (cfg_wr && cfg_idx < mavg_pkg::CH_LIMIT) begin
        order_r[cfg_idx] <= pwdata[mavg_pkg::ORDER_W-1:0];
        sum_r[cfg_idx]   <= '0;
        pos_r[cfg_idx]   <= '0;
        fill_r[cfg_idx]  <= '0;
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < divisor_r)
    else $error("divider remainder not below divisor");

  a_upd_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> state_r == S_DIV)
    else $error("sum update not followed by division");

  for (genvar g = 0; g < NCH; g++) begin : g_chk
    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
      FILL_W'(pos_r[g]) < eff_order(order_r[g]))
      else $error("ring position outside window");

    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r[g] <= eff_order(order_r[g]))
      else $error("fill count beyond window");
  end

endmodule
